/* rtl/core/dlpg_pkg.sv */
package dlpg_pkg;

	localparam int COORD_BITS = 6;
	localparam int ACC_BITS   = COORD_BITS + 3;

	typedef struct packed {
		logic [COORD_BITS-1:0] start_x;
		logic [COORD_BITS-1:0] start_z;
		logic [COORD_BITS-1:0] end_x;
		logic [COORD_BITS-1:0] end_z;
	} in_item_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] point_x;
		logic [COORD_BITS-1:0] point_z;
		logic                  last_point;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic setup;
		logic step;
	} dp_cmd_t;

	typedef struct packed {
		logic degenerate;
		logic last;
	} dp_status_t;

endpackage

/* rtl/core/dda_line_point_generator_top.sv */
// channel   direction  payload      handshake
// in        input      in_item_t    in_valid / in_ready
// out       output     out_item_t   out_valid / out_ready
//
// a segment is accepted in idle, set up in the setup state, then gives span+1 points (up to 64),
// stepped by the single accumulator of the datapath
// coincident endpoints return to idle after setup with no output
// arst_n clears the controller to idle; datapath registers need no reset
// a stalled output holds the current point; no new segment is taken until the last point leaves
module dda_line_point_generator_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  dlpg_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output dlpg_pkg::out_item_t out_data
);
	import dlpg_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	dlpg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	dlpg_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.status   (status),
		.out_data (out_data)
	);

endmodule

/* rtl/core/dlpg_ctrl.sv */
module dlpg_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  dlpg_pkg::dp_status_t status,
	output dlpg_pkg::dp_cmd_t    cmd
);
	import dlpg_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = ST_SETUP;
				end
			end
			ST_SETUP: begin
				state_nxt = status.degenerate ? ST_IDLE : ST_EMIT;
			end
			ST_EMIT: begin
				if (out_ready && status.last) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				cmd.step  = out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output handshakes open together");

	a_accept_to_setup: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_SETUP))
		else $error("accepted transaction did not enter setup");
`endif

endmodule

/* rtl/core/dlpg_datapath.sv */
module dlpg_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dlpg_pkg::in_item_t   in_data,
	input  dlpg_pkg::dp_cmd_t    cmd,
	output dlpg_pkg::dp_status_t status,
	output dlpg_pkg::out_item_t  out_data
);
	import dlpg_pkg::*;

	localparam int C = COORD_BITS;
	localparam int W = ACC_BITS;

	in_item_t              in_q;
	logic                  zmajor_q;
	logic [C-1:0]          span_q;
	logic [C-1:0]          left_q;
	logic [C-1:0]          major_q;
	logic [C-1:0]          minor_q;
	logic signed [W-1:0]   dmin2_q;
	logic signed [W-1:0]   rem_q;

	logic signed [C:0]     dx;
	logic signed [C:0]     dz;
	logic signed [C:0]     adx_full;
	logic signed [C:0]     adz_full;
	logic [C-1:0]          adx;
	logic [C-1:0]          adz;
	logic                  zmajor;
	logic [C-1:0]          span;
	logic [C-1:0]          lo_major;
	logic [C-1:0]          lo_minor;
	logic signed [C:0]     dmin;
	logic signed [W-1:0]   twod;
	logic signed [W-1:0]   sum;

	always_comb begin
		dx       = $signed({1'b0, in_q.end_x}) - $signed({1'b0, in_q.start_x});
		dz       = $signed({1'b0, in_q.end_z}) - $signed({1'b0, in_q.start_z});
		adx_full = dx[C] ? -dx : dx;
		adz_full = dz[C] ? -dz : dz;
		adx      = adx_full[C-1:0];
		adz      = adz_full[C-1:0];
		zmajor   = adz > adx;
		if (zmajor) begin
			span = adz;
			if (!dz[C]) begin
				lo_major = in_q.start_z;
				lo_minor = in_q.start_x;
				dmin     = dx;
			end else begin
				lo_major = in_q.end_z;
				lo_minor = in_q.end_x;
				dmin     = -dx;
			end
		end else begin
			span = adx;
			if (!dx[C]) begin
				lo_major = in_q.start_x;
				lo_minor = in_q.start_z;
				dmin     = dz;
			end else begin
				lo_major = in_q.end_x;
				lo_minor = in_q.end_z;
				dmin     = -dz;
			end
		end
	end

	assign twod = $signed({2'b00, span_q, 1'b0});
	assign sum  = rem_q + dmin2_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q <= in_data;
		end
		if (cmd.setup) begin
			zmajor_q <= zmajor;
			span_q   <= span;
			left_q   <= span;
			major_q  <= lo_major;
			minor_q  <= lo_minor;
			dmin2_q  <= $signed({dmin[C], dmin, 1'b0});
			rem_q    <= $signed({3'b000, span});
		end else if (cmd.step) begin
			major_q <= major_q + C'(1);
			left_q  <= left_q - C'(1);
			if (sum >= twod) begin
				rem_q   <= sum - twod;
				minor_q <= minor_q + C'(1);
			end else if (sum < 0) begin
				rem_q   <= sum + twod;
				minor_q <= minor_q - C'(1);
			end else begin
				rem_q <= sum;
			end
		end
	end

	assign status.degenerate = (adx == '0) && (adz == '0);
	assign status.last       = (left_q == '0);

	assign out_data.point_x    = zmajor_q ? minor_q : major_q;
	assign out_data.point_z    = zmajor_q ? major_q : minor_q;
	assign out_data.last_point = status.last;

`ifndef ASSERT_OFF
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.step) |-> (rem_q >= 0) && (rem_q < twod))
		else $error("step remainder left its range");

	a_major_advance: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |=> (major_q == $past(major_q) + 1'b1) && (left_q == $past(left_q) - 1'b1))
		else $error("major coordinate and step count out of lockstep");
`endif

endmodule

/* bench/tb_dda_line_point_generator_top.sv */
`timescale 1ns / 100ps

module tb_dda_line_point_generator_top;
	import dlpg_pkg::*;

	localparam int CMAX = (1 << COORD_BITS) - 1;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int LONG_HOLD = 300;
	localparam int DRAIN_CYCLES = 70;
	localparam int ITEMS_PER_PHASE = 100;

	typedef struct {
		in_item_t  seg;
		int        typed_count;
		out_item_t head;
		out_item_t tail;
	} seg_row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;

	out_item_t expected_points[$];
	seg_row_t  directed_rows[$];
	int        failures = 0;
	int        cycle_count = 0;
	int        send_idle_pct = 0;
	int        stall_pct = 0;
	int        hold_left = 0;
	bit        long_hold_req = 1'b0;

	dda_line_point_generator_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// receiver: random stalls plus one long hold-off
	always @(posedge clk) begin
		if (long_hold_req) begin
			hold_left = LONG_HOLD;
			long_hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_points.size() == 0) begin
				failures++;
				$display("%0t: unexpected point transaction, got x=%0d z=%0d last=%0b",
					$time, out_data.point_x, out_data.point_z, out_data.last_point);
			end else begin
				out_item_t want;
				want = expected_points.pop_front();
				if (out_data.point_x !== want.point_x || out_data.point_z !== want.point_z ||
						out_data.last_point !== want.last_point) begin
					failures++;
					$display("%0t: expected x=%0d z=%0d last=%0b, got x=%0d z=%0d last=%0b",
						$time, want.point_x, want.point_z, want.last_point,
						out_data.point_x, out_data.point_z, out_data.last_point);
				end
			end
		end
	end

	// walk the major axis from the lower end, minor coordinate rounded half up
	function automatic void rasterize_segment(in_item_t seg);
		int ax, az, bx, bz, dx, dz, adx, adz;
		int lo_major, lo_minor, dmin, span, num, mnr;
		bit zmajor;
		out_item_t pt;
		ax = int'(seg.start_x);
		az = int'(seg.start_z);
		bx = int'(seg.end_x);
		bz = int'(seg.end_z);
		dx = bx - ax;
		dz = bz - az;
		adx = (dx < 0) ? -dx : dx;
		adz = (dz < 0) ? -dz : dz;
		zmajor = adz > adx;
		if (adx == 0 && adz == 0)
			return;
		if (zmajor) begin
			span = adz;
			if (az <= bz) begin
				lo_major = az; lo_minor = ax; dmin = dx;
			end else begin
				lo_major = bz; lo_minor = bx; dmin = -dx;
			end
		end else begin
			span = adx;
			if (ax <= bx) begin
				lo_major = ax; lo_minor = az; dmin = dz;
			end else begin
				lo_major = bx; lo_minor = bz; dmin = -dz;
			end
		end
		for (int k = 0; k <= span; k++) begin
			num = 2 * (lo_minor * span + k * dmin) + span;
			if (num < 0)
				num = 0;
			mnr = num / (2 * span);
			if (zmajor) begin
				pt.point_x = COORD_BITS'(mnr);
				pt.point_z = COORD_BITS'(lo_major + k);
			end else begin
				pt.point_x = COORD_BITS'(lo_major + k);
				pt.point_z = COORD_BITS'(mnr);
			end
			pt.last_point = (k == span);
			expected_points = {expected_points, pt};
		end
	endfunction

	function automatic int near_coord(int c);
		int v;
		v = c + int'($urandom_range(0, 6)) - 3;
		if (v < 0)
			v = 0;
		if (v > CMAX)
			v = CMAX;
		return v;
	endfunction

	function automatic in_item_t random_segment();
		in_item_t seg;
		int kind, sx, sz, ex, ez, d;
		kind = $urandom_range(0, 9);
		sx = $urandom_range(0, CMAX);
		sz = $urandom_range(0, CMAX);
		ex = $urandom_range(0, CMAX);
		ez = $urandom_range(0, CMAX);
		case (kind)
			0: begin
				ex = sx; ez = sz;
			end
			1: ex = sx;
			2: ez = sz;
			3: begin
				d = (ex > sx) ? ex - sx : sx - ex;
				if (sz < d && sz + d > CMAX)
					sz = d;
				if ($urandom_range(0, 1) && sz + d <= CMAX)
					ez = sz + d;
				else if (sz >= d)
					ez = sz - d;
				else
					ez = sz + d;
			end
			4, 5: begin
				ex = near_coord(sx); ez = near_coord(sz);
			end
			default: ;
		endcase
		seg.start_x = COORD_BITS'(sx);
		seg.start_z = COORD_BITS'(sz);
		seg.end_x = COORD_BITS'(ex);
		seg.end_z = COORD_BITS'(ez);
		return seg;
	endfunction

	task automatic add_row(input int ax, az, bx, bz, input int n,
			input int hx, hz, tx, tz);
		seg_row_t r;
		r.seg = '{COORD_BITS'(ax), COORD_BITS'(az), COORD_BITS'(bx), COORD_BITS'(bz)};
		r.typed_count = n;
		r.head = '{COORD_BITS'(hx), COORD_BITS'(hz), 1'b0};
		r.tail = '{COORD_BITS'(tx), COORD_BITS'(tz), 1'b1};
		directed_rows = {directed_rows, r};
	endtask

	// typed_count below zero: expectation comes from the predictor
	task automatic offer_segment(input in_item_t seg, input int typed_count,
			input out_item_t head, input out_item_t tail);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_data <= seg;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (typed_count < 0) begin
			rasterize_segment(seg);
		end else if (typed_count == 2) begin
			expected_points = {expected_points, head};
			expected_points = {expected_points, tail};
		end
	endtask

	task automatic drain_points();
		in_valid <= 1'b0;
		while (expected_points.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int idle_by_phase[4];
		int stall_by_phase[4];
		idle_by_phase = '{0, 73, 0, 34};
		stall_by_phase = '{0, 0, 73, 34};

		// coincident, short, vertical and equal-span cases with typed points
		add_row(0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(63, 63, 63, 63, 0, 0, 0, 0, 0);
		add_row(0, 0, 1, 0, 2, 0, 0, 1, 0);
		add_row(63, 63, 62, 63, 2, 62, 63, 63, 63);
		add_row(5, 0, 5, 1, 2, 5, 0, 5, 1);
		add_row(0, 63, 0, 62, 2, 0, 62, 0, 63);
		add_row(1, 1, 0, 0, 2, 0, 0, 1, 1);
		// full-range diagonals and axes, reversed ends, half-way rounding
		add_row(0, 0, 63, 63, -1, 0, 0, 0, 0);
		add_row(63, 0, 0, 63, -1, 0, 0, 0, 0);
		add_row(0, 63, 63, 0, -1, 0, 0, 0, 0);
		add_row(63, 63, 0, 0, -1, 0, 0, 0, 0);
		add_row(0, 0, 63, 0, -1, 0, 0, 0, 0);
		add_row(63, 0, 0, 0, -1, 0, 0, 0, 0);
		add_row(0, 0, 0, 63, -1, 0, 0, 0, 0);
		add_row(0, 0, 63, 1, -1, 0, 0, 0, 0);
		add_row(0, 0, 1, 63, -1, 0, 0, 0, 0);
		add_row(0, 0, 2, 1, -1, 0, 0, 0, 0);
		add_row(2, 1, 0, 0, -1, 0, 0, 0, 0);
		add_row(0, 1, 2, 0, -1, 0, 0, 0, 0);
		add_row(1, 0, 0, 2, -1, 0, 0, 0, 0);
		add_row(10, 20, 30, 25, -1, 0, 0, 0, 0);
		add_row(42, 7, 13, 50, -1, 0, 0, 0, 0);
		add_row(21, 42, 42, 21, -1, 0, 0, 0, 0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			offer_segment(directed_rows[i].seg, directed_rows[i].typed_count,
				directed_rows[i].head, directed_rows[i].tail);
		drain_points();

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = idle_by_phase[ph];
			stall_pct = stall_by_phase[ph];
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				if (ph == 0 && i == 20)
					long_hold_req = 1'b1;
				offer_segment(random_segment(), -1, '0, '0);
			end
			drain_points();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
